// ===== rtl/temp_reading_to_display_digits_core_defines.svh =====
// Assertion macros shared by the checker files.
`ifndef TEMP_READING_TO_DISPLAY_DIGITS_CORE_DEFINES_SVH
`define TEMP_READING_TO_DISPLAY_DIGITS_CORE_DEFINES_SVH

// Same-cycle implication, switched off while reset is asserted.
`define TRDD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("trdd check failed");

// Next-cycle implication, switched off while reset is asserted.
`define TRDD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("trdd check failed");

// Next-cycle implication that also holds through reset.
`define TRDD_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("trdd check failed");

`endif

// ===== rtl/trdd_pkg.sv =====
// Shared types and constants for the temperature to display digits block.
package trdd_pkg;

    localparam int RAW_W     = 12;
    localparam int VAL_W     = 14;   // holds up to 12800 hundredths
    localparam int DIG_W     = 4;
    localparam int NUM_CELLS = 3;
    localparam int DP_W      = 2;

    // v / 10 == (v * 52429) >> 19 for every v below 43690
    localparam int RECIP_SHIFT = 19;
    localparam int PROD_W      = VAL_W + RECIP_SHIFT;
    localparam logic [PROD_W-1:0] RECIP_10 = PROD_W'(52429);

    typedef logic [DIG_W-1:0] t_digit;

    localparam t_digit CODE_MINUS = t_digit'(10);
    localparam t_digit CODE_BLANK = t_digit'(11);

    localparam logic [DP_W-1:0] DP_CELSIUS    = DP_W'(2);
    localparam logic [DP_W-1:0] DP_FAHRENHEIT = DP_W'(1);

    // Data handed from cell to cell: remaining quotient plus collected digits.
    typedef struct packed {
        logic [VAL_W-1:0]               value;
        t_digit [NUM_CELLS-1:0]         digits;
        logic                           neg;
        logic                           celsius;
    } t_stage;

endpackage

// ===== rtl/trdd_if.sv =====
// Valid/ready channel interfaces for readings and digit results.
interface trdd_in_if;
    import trdd_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [RAW_W-1:0] raw_temp;

    modport source (output valid, output raw_temp, input ready);
    modport sink   (input valid, input raw_temp, output ready);
endinterface

interface trdd_out_if;
    import trdd_pkg::*;
    logic            valid;
    logic            ready;
    logic [3:0]      digit0;
    logic [3:0]      digit1;
    logic [3:0]      digit2;
    logic [3:0]      digit3;
    logic [DP_W-1:0] decimal_position;

    modport source (output valid, output digit0, output digit1, output digit2,
                    output digit3, output decimal_position, input ready);
    modport sink   (input valid, input digit0, input digit1, input digit2,
                    input digit3, input decimal_position, output ready);
endinterface

// ===== rtl/trdd_prep.sv =====
// Front stage: scales the reading to hundredths (C) or tenths (F) magnitude.
module trdd_prep import trdd_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic signed [RAW_W-1:0] i_raw_temp,
    input  logic                    i_celsius,
    output logic                    o_valid,
    input  logic                    i_ready,
    output t_stage                  o_data
);

    logic                    r_valid;
    t_stage                  r_data;
    t_stage                  n_data;

    logic [RAW_W-1:0]        w_mag;
    logic [VAL_W-1:0]        w_mag_x;
    logic [VAL_W-1:0]        w_cent;
    logic signed [RAW_W:0]   w_t;
    logic signed [RAW_W:0]   w_bias;
    logic signed [RAW_W:0]   w_div8;
    logic signed [RAW_W:0]   w_f;
    logic [RAW_W-1:0]        w_fmag;

    // Celsius: 6*m + floor(m/4)
    assign w_mag   = i_raw_temp[RAW_W-1] ? (~i_raw_temp + RAW_W'(1)) : i_raw_temp;
    assign w_mag_x = VAL_W'(w_mag);
    assign w_cent  = (w_mag_x << 2) + (w_mag_x << 1) + VAL_W'(w_mag[RAW_W-1:2]);

    // Fahrenheit: (t+4)/8 truncated toward zero, + t + 320
    assign w_t    = {i_raw_temp[RAW_W-1], i_raw_temp};
    assign w_bias = w_t + (RAW_W+1)'(4);
    assign w_div8 = w_bias[RAW_W] ? ((w_bias + (RAW_W+1)'(7)) >>> 3) : (w_bias >>> 3);
    assign w_f    = w_div8 + w_t + (RAW_W+1)'(320);
    assign w_fmag = RAW_W'(w_f[RAW_W] ? -w_f : w_f);

    always_comb begin
        n_data         = '0;
        n_data.celsius = i_celsius;
        if (i_celsius) begin
            n_data.neg   = i_raw_temp[RAW_W-1];
            n_data.value = w_cent;
        end else begin
            n_data.neg   = w_f[RAW_W];
            n_data.value = VAL_W'(w_fmag);
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== rtl/trdd_cell.sv =====
// Digit cell: divides the value by ten and shifts the remainder into the digit line.
module trdd_cell import trdd_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_stage i_data,
    output logic   o_valid,
    input  logic   i_ready,
    output t_stage o_data
);

    logic             r_valid;
    t_stage           r_data;
    t_stage           n_data;
    logic [PROD_W-1:0] w_prod;
    logic [VAL_W-1:0] w_quot;
    logic [VAL_W-1:0] w_tens;
    t_digit           w_rem;

    // reciprocal multiply, exact over the whole value range
    assign w_prod = PROD_W'(i_data.value) * RECIP_10;
    assign w_quot = w_prod[PROD_W-1:RECIP_SHIFT];
    assign w_tens = (w_quot << 3) + (w_quot << 1);
    assign w_rem  = DIG_W'(i_data.value - w_tens);

    always_comb begin
        n_data        = i_data;
        n_data.value  = w_quot;
        n_data.digits = {w_rem, i_data.digits[NUM_CELLS-1:1]};
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== rtl/trdd_fmt.sv =====
// Output stage: blanking, minus sign, Celsius shift and the result register.
module trdd_fmt import trdd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_stage      i_data,
    trdd_out_if.source  o_out
);

    typedef struct packed {
        t_digit          d0;
        t_digit          d1;
        t_digit          d2;
        t_digit          d3;
        logic [DP_W-1:0] dp;
    } t_result;

    logic    r_valid;
    t_result r_res;
    t_result n_res;
    t_digit  w_q3;

    assign w_q3 = DIG_W'(i_data.value);

    always_comb begin
        n_res.d0 = i_data.digits[0];
        n_res.d1 = i_data.digits[1];
        n_res.d2 = i_data.digits[2];
        n_res.d3 = w_q3;
        n_res.dp = i_data.celsius ? DP_CELSIUS : DP_FAHRENHEIT;
        if (w_q3 == '0) begin
            n_res.d3 = CODE_BLANK;
            if (!i_data.celsius && i_data.digits[2] == '0) begin
                n_res.d2 = CODE_BLANK;
            end
        end
        if (i_data.neg) begin
            // ten degrees or more below zero: drop the last digit
            if (i_data.celsius && w_q3 != '0) begin
                n_res.dp = DP_FAHRENHEIT;
                n_res.d0 = i_data.digits[1];
                n_res.d1 = i_data.digits[2];
                n_res.d2 = w_q3;
            end
            n_res.d3 = CODE_MINUS;
        end
    end

    assign o_ready = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid            = r_valid;
    assign o_out.digit0           = r_res.d0;
    assign o_out.digit1           = r_res.d1;
    assign o_out.digit2           = r_res.d2;
    assign o_out.digit3           = r_res.d3;
    assign o_out.decimal_position = r_res.dp;

endmodule

// ===== rtl/temp_reading_to_display_digits_core.sv =====
// Top level: temperature reading to four display digit codes.
//
// Usage:
//   i_in carries one signed 12-bit reading (1/16 degree C) per transfer.
//   o_out carries four digit codes (0-9, 10 minus, 11 blank) and the digit
//   index that shows the decimal point. i_cfg_we/i_cfg_wdata write the unit
//   register (1 Celsius hundredths, 0 Fahrenheit tenths); write it only
//   while no reading is in flight.
// A reading passes through five registers in order: a scaling stage, three
// divide-by-ten cells and the output register. Throughput is one reading per
// cycle while o_out.ready stays high; each cell's single constant multiply
// sets the stage timing.
// Reset (synchronous, active low) empties every stage and selects Celsius.
// When the receiver stalls, the result holds on o_out and the stages behind
// it keep filling; i_in.ready drops only once every stage holds a reading.
module temp_reading_to_display_digits_core import trdd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    trdd_in_if.sink    i_in,
    trdd_out_if.source o_out
);

    logic                 r_unit_celsius;
    logic [NUM_CELLS:0]   w_valid;
    logic [NUM_CELLS:0]   w_ready;
    t_stage [NUM_CELLS:0] w_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit_celsius <= 1'b1;
        end else if (i_cfg_we) begin
            r_unit_celsius <= i_cfg_wdata;
        end
    end

    trdd_prep u_prep (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in.valid),
        .o_ready    (i_in.ready),
        .i_raw_temp (i_in.raw_temp),
        .i_celsius  (r_unit_celsius),
        .o_valid    (w_valid[0]),
        .i_ready    (w_ready[0]),
        .o_data     (w_data[0])
    );

    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        trdd_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .o_ready (w_ready[g]),
            .i_data  (w_data[g]),
            .o_valid (w_valid[g+1]),
            .i_ready (w_ready[g+1]),
            .o_data  (w_data[g+1])
        );
    end

    trdd_fmt u_fmt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid[NUM_CELLS]),
        .o_ready (w_ready[NUM_CELLS]),
        .i_data  (w_data[NUM_CELLS]),
        .o_out   (o_out)
    );

endmodule

// ===== rtl/trdd_checker.sv =====
// Port-level checks on the result channel, bound to the top level.
`include "temp_reading_to_display_digits_core_defines.svh"

module trdd_checker import trdd_pkg::*; (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_out_valid,
    input logic            i_out_ready,
    input logic [3:0]      i_digit0,
    input logic [3:0]      i_digit1,
    input logic [3:0]      i_digit2,
    input logic [3:0]      i_digit3,
    input logic [DP_W-1:0] i_decimal_position
);

    // a stalled result keeps its payload
    `TRDD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable({i_digit0, i_digit1, i_digit2, i_digit3, i_decimal_position}))

    // no result comes out of a pipeline that was just reset
    `TRDD_ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !i_out_valid)

    // decimal point sits on digit 1 or digit 2 only
    `TRDD_ASSERT_NOW(a_dp_range, i_clk, i_rst_n, i_out_valid, i_decimal_position == DP_CELSIUS || i_decimal_position == DP_FAHRENHEIT)

    // rightmost digit is always a real digit, also after the Celsius shift
    `TRDD_ASSERT_NOW(a_d0_digit, i_clk, i_rst_n, i_out_valid, i_digit0 <= 4'd9)

    // point on digit 1 shows a non-blank digit there
    `TRDD_ASSERT_NOW(a_d1_shown, i_clk, i_rst_n, i_out_valid && i_decimal_position == DP_FAHRENHEIT, i_digit1 <= 4'd9)

endmodule

bind temp_reading_to_display_digits_core trdd_checker u_trdd_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_out_valid        (o_out.valid),
    .i_out_ready        (o_out.ready),
    .i_digit0           (o_out.digit0),
    .i_digit1           (o_out.digit1),
    .i_digit2           (o_out.digit2),
    .i_digit3           (o_out.digit3),
    .i_decimal_position (o_out.decimal_position)
);

// ===== verif/reading_digits_checker.sv =====
// Watches the reading and digit channels, predicts each digit set and compares it.
module reading_digits_checker import trdd_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic                    i_cfg_wdata,
    input  logic                    i_in_valid,
    input  logic                    i_in_ready,
    input  logic signed [RAW_W-1:0] i_raw_temp,
    input  logic                    i_out_valid,
    input  logic                    i_out_ready,
    input  t_digit                  i_digit0,
    input  t_digit                  i_digit1,
    input  t_digit                  i_digit2,
    input  t_digit                  i_digit3,
    input  logic [DP_W-1:0]         i_decimal_position,
    output int                      o_pending,
    output int                      o_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_digit          d3;
        t_digit          d2;
        t_digit          d1;
        t_digit          d0;
        logic [DP_W-1:0] dp;
    } t_shown_digits;

    logic          unit_celsius = 1'b1;
    t_shown_digits digits_due[$];
    int            fail_count = 0;

    function automatic t_shown_digits digits_for_reading(input logic signed [RAW_W-1:0] raw,
                                                         input logic celsius);
        t_shown_digits s;
        int            t;
        int            f;
        int            mag;
        int            val;
        logic          neg;
        t = int'(raw);
        if (celsius) begin
            neg  = (t < 0);
            mag  = neg ? -t : t;
            val  = 6 * mag + mag / 4;     // x6.25 -> hundredths
            s.dp = DP_CELSIUS;
        end else begin
            f    = (t + 4) / 8 + t + 320; // SV division truncates towards zero
            neg  = (f < 0);
            val  = neg ? -f : f;
            s.dp = DP_FAHRENHEIT;
        end
        s.d3 = t_digit'(val / 1000);
        s.d2 = t_digit'((val / 100) % 10);
        s.d1 = t_digit'((val / 10) % 10);
        s.d0 = t_digit'(val % 10);
        if (val < 1000) begin
            s.d3 = CODE_BLANK;
            if (s.d2 == t_digit'(0) && s.dp == DP_FAHRENHEIT)
                s.d2 = CODE_BLANK;
        end
        if (neg) begin
            // ten degrees or colder: shift right, lose hundredths, point on digit 1
            if (celsius && val >= 1000) begin
                s.dp = DP_FAHRENHEIT;
                s.d0 = s.d1;
                s.d1 = s.d2;
                s.d2 = s.d3;
            end
            s.d3 = CODE_MINUS;
        end
        return s;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_shown_digits got;
        t_shown_digits want;
        if (!i_rst_n) begin
            unit_celsius = 1'b1;
            digits_due.delete();
        end else begin
            if (i_cfg_we)
                unit_celsius = i_cfg_wdata;
            // result side first so a same-edge reading cannot satisfy it
            if (i_out_valid && i_out_ready) begin
                got = '{i_digit3, i_digit2, i_digit1, i_digit0, i_decimal_position};
                if (digits_due.size() == 0) begin
                    $error("digit transfer with nothing expected: %h", got);
                    fail_count++;
                end else begin
                    want = digits_due.pop_front();
                    check_field("digit0", want.d0, got.d0);
                    check_field("digit1", want.d1, got.d1);
                    check_field("digit2", want.d2, got.d2);
                    check_field("digit3", want.d3, got.d3);
                    check_field("decimal_position", want.dp, got.dp);
                end
            end
            if (i_in_valid && i_in_ready)
                digits_due.push_back(digits_for_reading(i_raw_temp, unit_celsius));
        end
        o_pending <= digits_due.size();
        o_errors  <= fail_count;
    end

endmodule

// ===== verif/tb.sv =====
// Top of the testbench: clock, reset, reading stimulus, result stalls and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import trdd_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;
    int   n_pending;
    int   n_fail;

    int   rx_cycle = 0;
    int   rx_mode  = 0;
    int   rx_hold  = 0;

    trdd_in_if  rd_ch ();
    trdd_out_if dg_ch ();

    temp_reading_to_display_digits_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (rd_ch),
        .o_out       (dg_ch)
    );

    reading_digits_checker checker_i (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_in_valid         (rd_ch.valid),
        .i_in_ready         (rd_ch.ready),
        .i_raw_temp         (rd_ch.raw_temp),
        .i_out_valid        (dg_ch.valid),
        .i_out_ready        (dg_ch.ready),
        .i_digit0           (dg_ch.digit0),
        .i_digit1           (dg_ch.digit1),
        .i_digit2           (dg_ch.digit2),
        .i_digit3           (dg_ch.digit3),
        .i_decimal_position (dg_ch.decimal_position),
        .o_pending          (n_pending),
        .o_errors           (n_fail)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Result side stalls in one of four styles, drawn again at random.
    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 50 == 0)
            rx_mode <= $urandom_range(0, 3);
        case (rx_mode)
            0: dg_ch.ready <= 1'b1;
            1: dg_ch.ready <= 1'($urandom_range(0, 1));
            2: dg_ch.ready <= (rx_cycle % 3 != 0);
            default: begin
                if (rx_hold > 0) begin
                    rx_hold     <= rx_hold - 1;
                    dg_ch.ready <= 1'b0;
                end else begin
                    dg_ch.ready <= 1'b1;
                    rx_hold     <= ($urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
                end
            end
        endcase
    end

    task automatic push_reading(input logic signed [RAW_W-1:0] reading);
        rd_ch.valid    <= 1'b1;
        rd_ch.raw_temp <= reading;
        do @(posedge i_clk); while (!rd_ch.ready);
    endtask

    // Drop valid and wait until every digit set has come back.
    task automatic drain_readings();
        rd_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (n_pending != 0)
            @(posedge i_clk);
    endtask

    task automatic set_unit(input logic celsius);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= celsius;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic signed [RAW_W-1:0] pick_reading();
        int r;
        case ($urandom_range(0, 9)) inside
            [0:5]:   r = int'($urandom_range(0, 4095)) - 2048;
            [6:7]:   r = int'($urandom_range(0, 700)) - 350;  // leading blanks, sign flip
            8:       r = ($urandom_range(0, 1) == 1) ? 2047 - int'($urandom_range(0, 40))
                                                     : -2048 + int'($urandom_range(0, 40));
            default: r = -160 + int'($urandom_range(0, 16)) - 8; // -10 C shift boundary
        endcase
        return RAW_W'(r);
    endfunction

    task automatic run_phase(input int count);
        int sent;
        int burst;
        int gap;
        sent = 0;
        while (sent < count) begin
            burst = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
            for (int k = 0; k < burst && sent < count; k++) begin
                push_reading(pick_reading());
                sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                rd_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    initial begin : stimulus
        int corner_readings [12] = '{0, -1, 2047, -2048, 1599, 1600,
                                     -159, -160, -285, -286, -13, -5};
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_wdata    <= 1'b0;
        rd_ch.valid    <= 1'b0;
        rd_ch.raw_temp <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // corners first in the reset unit (Celsius), then in Fahrenheit
        foreach (corner_readings[k])
            push_reading(RAW_W'(corner_readings[k]));
        drain_readings();
        set_unit(1'b0);
        foreach (corner_readings[k])
            push_reading(RAW_W'(corner_readings[k]));
        drain_readings();

        for (int p = 0; p < 8; p++) begin
            set_unit((p == 0) ? 1'b1 : (p == 1) ? 1'b0 : 1'($urandom_range(0, 1)));
            run_phase(235);
            drain_readings();
        end

        repeat (10) @(posedge i_clk);
        if (n_fail == 0 && n_pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/trdd_pkg.sv
rtl/trdd_if.sv
rtl/trdd_prep.sv
rtl/trdd_cell.sv
rtl/trdd_fmt.sv
rtl/temp_reading_to_display_digits_core.sv
rtl/trdd_checker.sv
verif/reading_digits_checker.sv
verif/tb.sv
